// ===== sv/sgm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Sobel gradient magnitude block.
// Used by every module of the block; depends on nothing.
package sgm_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SIZE_W      = 12;
    localparam int PIX_W       = 8;
    localparam int POS_W       = 11;
    localparam int CFG_IDX_W   = 4;
    localparam int ABS_W       = 10;
    localparam int SUM_W       = 2 * ABS_W + 1;
    localparam int ROOT_W      = 16;
    localparam int SQRT_STEPS  = ROOT_W / 2;
    localparam int STEP_W      = $clog2(SQRT_STEPS);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int MIN_SIZE    = 3;
    localparam int MAG_MAX     = 255;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic             interior;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             last;
    } pix_item_t;

    typedef struct packed {
        logic [ABS_W-1:0] ax;
        logic [ABS_W-1:0] ay;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             last;
    } grad_item_t;

endpackage

// ===== sv/sgm_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers and raster position tracking.
// Tags each accepted pixel with its position and border class; uses sgm_pkg.
module sgm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgm_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sgm_pkg::PIX_W-1:0]      s_pixel_luma,
    input  logic                           s_frame_start,
    output logic                           push,
    output sgm_pkg::pix_item_t             push_item,
    input  logic                           push_ready
);
    import sgm_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] w_lim, h_lim;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic [SIZE_W-1:0] c_ext, r_ext, c_inc, r_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = push_ready;
    assign push      = s_valid && push_ready;

    always_comb begin
        if (width_reg < SIZE_W'(MIN_SIZE)) begin
            w_lim = SIZE_W'(MIN_SIZE);
        end else if (width_reg > SIZE_W'(MAX_WIDTH)) begin
            w_lim = SIZE_W'(MAX_WIDTH);
        end else begin
            w_lim = width_reg;
        end
        if (height_reg < SIZE_W'(MIN_SIZE)) begin
            h_lim = SIZE_W'(MIN_SIZE);
        end else if (height_reg > SIZE_W'(MAX_HEIGHT)) begin
            h_lim = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_lim = height_reg;
        end
    end

    always_comb begin
        c_ext = s_frame_start ? '0 : SIZE_W'(col_reg);
        r_ext = s_frame_start ? '0 : SIZE_W'(row_reg);
        if (c_ext >= w_lim) begin
            c_ext = '0;
            r_ext = r_ext + SIZE_W'(1);
        end
        if (r_ext >= h_lim) begin
            r_ext = '0;
        end
        c_cur = c_ext[COL_W-1:0];
        r_cur = r_ext[ROW_W-1:0];

        c_inc = c_ext + SIZE_W'(1);
        r_inc = r_ext + SIZE_W'(1);
        if (c_inc >= w_lim) begin
            col_next = '0;
            row_next = (r_inc >= h_lim) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_cur;
        end

        push_item.pix      = s_pixel_luma;
        push_item.col      = c_cur;
        push_item.interior = (r_ext >= SIZE_W'(2)) && (c_ext >= SIZE_W'(2));
        push_item.out_col  = POS_W'(c_ext - SIZE_W'(1));
        push_item.out_row  = POS_W'(r_ext - SIZE_W'(1));
        push_item.last     = (r_ext == h_lim - SIZE_W'(1)) && (c_ext == w_lim - SIZE_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    width_reg <= cfg_data;
                end else if (cfg_index == REG_FRAME_HEIGHT) begin
                    height_reg <= cfg_data;
                end
            end
            if (push) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// ===== sv/sgm_fifo.sv =====
`timescale 1ns / 1ps
// Short register queue of tagged pixels between the front and back ends.
// Uses pix_item_t and the queue depth from sgm_pkg.
module sgm_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sgm_pkg::pix_item_t push_item,
    output logic               push_ready,
    input  logic               pop,
    output sgm_pkg::pix_item_t pop_item,
    output logic               pop_valid
);
    import sgm_pkg::*;

    pix_item_t          slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (FIFO_AW+1)'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count exceeds depth");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + (FIFO_AW+1)'(1))
        else $error("queue count missed a push");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("pop from empty queue");

endmodule

// ===== sv/sgm_back.sv =====
`timescale 1ns / 1ps
// Back end: two line memories, the 3x3 window and the Sobel sums.
// Hands absolute gradients of interior pixels on; uses sgm_pkg.
module sgm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  sgm_pkg::pix_item_t  q_item,
    output logic                q_pop,
    output logic                g_valid,
    output sgm_pkg::grad_item_t g_item,
    input  logic                g_ready
);
    import sgm_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } back_state_t;

    back_state_t      state_reg;
    pix_item_t        cur_reg;
    logic [PIX_W-1:0] line_a_mem [MAX_WIDTH];
    logic [PIX_W-1:0] line_b_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_a_reg, rd_b_reg;
    logic [PIX_W-1:0] window_reg [6];
    logic             g_valid_reg;
    grad_item_t       g_reg;

    logic [PIX_W-1:0]   top, mid, bot;
    logic [ABS_W-1:0]   pos_x, neg_x, pos_y, neg_y;
    logic signed [ABS_W:0] gx, gy;
    logic [ABS_W:0]     gx_abs, gy_abs;
    logic               proceed;

    assign top = rd_b_reg;
    assign mid = rd_a_reg;
    assign bot = cur_reg.pix;

    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign proceed = (state_reg == S_CALC) && (!cur_reg.interior || !g_valid_reg || g_ready);
    assign g_valid = g_valid_reg;
    assign g_item  = g_reg;

    always_comb begin
        pos_x  = ABS_W'(top) + ABS_W'({mid, 1'b0}) + ABS_W'(bot);
        neg_x  = ABS_W'(window_reg[0]) + ABS_W'({window_reg[2], 1'b0})
               + ABS_W'(window_reg[4]);
        pos_y  = ABS_W'(window_reg[4]) + ABS_W'({window_reg[5], 1'b0}) + ABS_W'(bot);
        neg_y  = ABS_W'(window_reg[0]) + ABS_W'({window_reg[1], 1'b0}) + ABS_W'(top);
        gx     = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
        gy     = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
        gx_abs = gx[ABS_W] ? (ABS_W+1)'(-gx) : (ABS_W+1)'(gx);
        gy_abs = gy[ABS_W] ? (ABS_W+1)'(-gy) : (ABS_W+1)'(gy);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_a_reg <= line_a_mem[q_item.col];
            rd_b_reg <= line_b_mem[q_item.col];
        end
        if (proceed) begin
            line_a_mem[cur_reg.col] <= bot;
            line_b_mem[cur_reg.col] <= mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            g_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            if (g_valid_reg && g_ready && !(proceed && cur_reg.interior)) begin
                g_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cur_reg   <= q_item;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (proceed) begin
                        window_reg[0] <= window_reg[1];
                        window_reg[1] <= top;
                        window_reg[2] <= window_reg[3];
                        window_reg[3] <= mid;
                        window_reg[4] <= window_reg[5];
                        window_reg[5] <= bot;
                        if (cur_reg.interior) begin
                            g_valid_reg   <= 1'b1;
                            g_reg.ax      <= gx_abs[ABS_W-1:0];
                            g_reg.ay      <= gy_abs[ABS_W-1:0];
                            g_reg.out_col <= cur_reg.out_col;
                            g_reg.out_row <= cur_reg.out_row;
                            g_reg.last    <= cur_reg.last;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_calc_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == S_CALC)
        else $error("memory read not followed by window update");

endmodule

// ===== sv/sgm_isqrt.sv =====
`timescale 1ns / 1ps
// Iterative integer square root of gx^2 + gy^2, two radicand bits per step.
// Clamps to 255 and holds the result register; uses sgm_pkg.
module sgm_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         g_valid,
    input  sgm_pkg::grad_item_t          g_item,
    output logic                         g_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sgm_pkg::PIX_W-1:0]    m_gradient_mag,
    output logic [sgm_pkg::POS_W-1:0]    m_out_col,
    output logic [sgm_pkg::POS_W-1:0]    m_out_row,
    output logic                         m_frame_last
);
    import sgm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_RUN,
        S_DONE
    } sqrt_state_t;

    sqrt_state_t       state_reg;
    grad_item_t        item_reg;
    logic [ROOT_W-1:0] rem_reg, root_reg, bit_reg;
    logic              big_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  mag_reg;

    logic [SUM_W-1:0]  sum;
    logic [ROOT_W-1:0] test, rem_new, root_new;

    assign g_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_gradient_mag = mag_reg;
    assign m_out_col      = item_reg.out_col;
    assign m_out_row      = item_reg.out_row;
    assign m_frame_last   = item_reg.last;

    always_comb begin
        sum  = SUM_W'(item_reg.ax) * SUM_W'(item_reg.ax)
             + SUM_W'(item_reg.ay) * SUM_W'(item_reg.ay);
        test = root_reg + bit_reg;
        if (rem_reg >= test) begin
            rem_new  = rem_reg - test;
            root_new = (root_reg >> 1) + bit_reg;
        end else begin
            rem_new  = rem_reg;
            root_new = root_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (g_valid) begin
                        item_reg  <= g_item;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    rem_reg   <= sum[ROOT_W-1:0];
                    big_reg   <= |sum[SUM_W-1:ROOT_W];
                    root_reg  <= '0;
                    bit_reg   <= ROOT_W'(1) << (ROOT_W - 2);
                    step_reg  <= '0;
                    state_reg <= S_RUN;
                end
                S_RUN: begin
                    rem_reg  <= rem_new;
                    root_reg <= root_new;
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                        mag_reg     <= big_reg ? PIX_W'(MAG_MAX) : root_new[PIX_W-1:0];
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_root_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> root_reg[ROOT_W-1:PIX_W] == '0)
        else $error("square root exceeds eight bits");

    a_valid_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg == (state_reg == S_DONE))
        else $error("result valid out of step with state");

endmodule

// ===== sv/sobel_gradient_magnitude.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Instantiates sgm_front, sgm_fifo, sgm_back and sgm_isqrt; uses sgm_pkg.
//
// Pixels enter in raster order on the s_ channel, one 8-bit luma value per
// request; s_frame_start marks pixel (0,0) of a frame. Each interior pixel
// yields one request on the m_ channel with the clamped floor of the
// gradient magnitude, its column and row and a last-of-frame flag. Border
// pixels yield nothing. frame_width and frame_height are written through the
// cfg_ channel (index 0 and 1); the user must write them only while the block
// is idle, which the block does not enforce; cfg_ready is always high. A
// border pixel never stalls in the back end. An interior pixel passes the
// queue, the back end and the eight-step square root unit, which takes one
// gradient at a time and so sets the result rate. A four-entry queue lets
// the front keep accepting while the back works. When the receiver stalls,
// the result holds in the output register, the queue fills and s_ready
// falls. Reset empties the queue, restores the frame size to 640 by 480 and
// restarts the position at (0,0); line memories are not cleared.
module sobel_gradient_magnitude (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgm_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sgm_pkg::PIX_W-1:0]     s_pixel_luma,
    input  logic                          s_frame_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sgm_pkg::PIX_W-1:0]     m_gradient_mag,
    output logic [sgm_pkg::POS_W-1:0]     m_out_col,
    output logic [sgm_pkg::POS_W-1:0]     m_out_row,
    output logic                          m_frame_last
);
    import sgm_pkg::*;

    logic       push, push_ready, q_pop, q_valid, g_valid, g_ready;
    pix_item_t  push_item, q_item;
    grad_item_t g_item;

    sgm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_luma  (s_pixel_luma),
        .s_frame_start (s_frame_start),
        .push          (push),
        .push_item     (push_item),
        .push_ready    (push_ready)
    );

    sgm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_item   (q_item),
        .pop_valid  (q_valid)
    );

    sgm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .g_valid (g_valid),
        .g_item  (g_item),
        .g_ready (g_ready)
    );

    sgm_isqrt u_isqrt (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .g_valid        (g_valid),
        .g_item         (g_item),
        .g_ready        (g_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gradient_mag (m_gradient_mag),
        .m_out_col      (m_out_col),
        .m_out_row      (m_out_row),
        .m_frame_last   (m_frame_last)
    );

endmodule
